// ===== hdl/lsps_pkg.sv =====
// shared types and constants for the longest simple path search unit
package lsps_pkg;

  localparam int FIELD_LIMIT      = 16;
  localparam int DEF_MAX_VERTICES = 16;
  localparam int VERTEX_W         = 4;
  localparam int COUNT_W          = 5;
  localparam int ROW_W            = 16;
  localparam int APB_DATA_W       = 32;
  localparam int APB_ADDR_W       = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // register index, taken from the word address
  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef struct packed {
    logic                opcode;
    logic [VERTEX_W-1:0] row_index;
    logic [ROW_W-1:0]    row_edges;
  } item_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [COUNT_W-1:0]  path_length;
    logic                is_last;
  } result_t;

  typedef struct packed {
    logic load;
    logic init;
    logic push_start;
    logic step;
    logic abort;
    logic emit_clear;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic start_ok;
    logic stack_empty;
    logic best_full;
    logic emit_last;
  } status_t;

  function automatic int row_limit(input int max_vertices);
    return (max_vertices < FIELD_LIMIT) ? max_vertices : FIELD_LIMIT;
  endfunction

endpackage

// ===== hdl/lsps_ctrl.sv =====
// controller state machine sequencing load, search steps and path output
module lsps_ctrl
  import lsps_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  logic    opcode,
  output logic    item_stall,
  output logic    result_valid,
  input  logic    result_stall,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_START = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign item_stall   = rst | (state != ST_IDLE);
  assign result_valid = (state == ST_EMIT);
  assign accept       = item_valid & ~item_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (opcode == OP_SEARCH) begin
            cmd.init   = 1'b1;
            state_next = ST_START;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_START: begin
        if (status.start_ok) begin
          cmd.push_start = 1'b1;
          state_next     = ST_STEP;
        end else begin
          cmd.emit_clear = 1'b1;
          state_next     = ST_EMIT;
        end
      end
      ST_STEP: begin
        if (status.stack_empty) begin
          state_next = ST_START;
        end else if (status.best_full) begin
          // a path already covers every vertex
          cmd.abort  = 1'b1;
          state_next = ST_START;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!result_stall) begin
          if (status.emit_last) begin
            state_next = ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/lsps_datapath.sv =====
// datapath: adjacency rows, search stacks, visited marks and best path
module lsps_datapath
  import lsps_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  item_t              item,
  input  logic [COUNT_W-1:0] active_count,
  output status_t            status,
  output result_t            result
);

  localparam int ROW_LIMIT = row_limit(MAX_VERTICES);
  localparam int IDX_W     = $clog2(ROW_LIMIT);

  logic [ROW_LIMIT-1:0] adj [ROW_LIMIT];
  logic [VERTEX_W-1:0]  path [ROW_LIMIT];
  logic [COUNT_W-1:0]   nn [ROW_LIMIT];
  logic [VERTEX_W-1:0]  best_path [ROW_LIMIT];
  logic [ROW_LIMIT-1:0] visited;
  logic [COUNT_W-1:0]   depth;
  logic [COUNT_W-1:0]   best_length;
  logic [COUNT_W-1:0]   start;
  logic [COUNT_W-1:0]   emit_idx;

  logic [COUNT_W-1:0]   top_pos;
  logic [IDX_W-1:0]     top_idx;
  logic [IDX_W-1:0]     depth_idx;
  logic [VERTEX_W-1:0]  top_vertex;
  logic [ROW_LIMIT-1:0] edges;
  logic [COUNT_W-1:0]   nn_top;
  logic [ROW_LIMIT-1:0] cand;
  logic                 found;
  logic [IDX_W-1:0]     found_idx;
  logic                 push_en;
  logic                 pop_en;
  logic [VERTEX_W-1:0]  push_vertex;
  logic [COUNT_W-1:0]   depth_inc;
  logic                 new_best;
  logic                 row_ok;

  assign top_pos    = depth - COUNT_W'(1);
  assign top_idx    = top_pos[IDX_W-1:0];
  assign depth_idx  = depth[IDX_W-1:0];
  assign top_vertex = path[top_idx];
  assign edges      = adj[top_vertex[IDX_W-1:0]];
  assign nn_top     = nn[top_idx];

  // next unvisited neighbour at or above the resume point, below the vertex count
  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int j = 0; j < ROW_LIMIT; j++) begin
      cand[j] = edges[j] & ~visited[j] & (COUNT_W'(j) < active_count) &
                (COUNT_W'(j) >= nn_top);
    end
    for (int j = ROW_LIMIT - 1; j >= 0; j--) begin
      if (cand[j]) begin
        found     = 1'b1;
        found_idx = IDX_W'(j);
      end
    end
  end

  assign push_en     = cmd.push_start | (cmd.step & found);
  assign pop_en      = cmd.step & ~found;
  assign push_vertex = cmd.push_start ? start[VERTEX_W-1:0] : VERTEX_W'(found_idx);
  assign depth_inc   = depth + COUNT_W'(1);
  assign new_best    = depth_inc > best_length;
  assign row_ok      = {1'b0, item.row_index} < COUNT_W'(ROW_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      visited     <= '0;
      depth       <= '0;
      best_length <= '0;
      start       <= '0;
      emit_idx    <= '0;
    end else begin
      if (cmd.init) begin
        visited     <= '0;
        depth       <= '0;
        best_length <= '0;
        start       <= '0;
      end
      if (cmd.abort) begin
        visited <= '0;
        depth   <= '0;
      end
      if (push_en) begin
        visited[push_vertex[IDX_W-1:0]] <= 1'b1;
        depth <= depth_inc;
        if (new_best) begin
          best_length <= depth_inc;
        end
        if (cmd.push_start) begin
          start <= start + COUNT_W'(1);
        end
      end
      if (pop_en) begin
        visited[top_vertex[IDX_W-1:0]] <= 1'b0;
        depth <= top_pos;
      end
      if (cmd.emit_clear) begin
        emit_idx <= '0;
      end
      if (cmd.emit_next) begin
        emit_idx <= emit_idx + COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && row_ok) begin
      adj[item.row_index[IDX_W-1:0]] <= item.row_edges[ROW_LIMIT-1:0];
    end
    if (push_en) begin
      path[depth_idx] <= push_vertex;
      nn[depth_idx]   <= '0;
      if (cmd.step) begin
        nn[top_idx] <= COUNT_W'(found_idx) + COUNT_W'(1);
      end
      if (new_best) begin
        for (int j = 0; j < ROW_LIMIT; j++) begin
          best_path[j] <= (IDX_W'(j) == depth_idx) ? push_vertex : path[j];
        end
      end
    end
  end

  assign status.start_ok    = (start < active_count) && (best_length < active_count);
  assign status.stack_empty = (depth == '0);
  assign status.best_full   = (best_length >= active_count);
  assign status.emit_last   = (emit_idx + COUNT_W'(1)) == best_length;

  assign result.vertex      = best_path[emit_idx[IDX_W-1:0]];
  assign result.path_length = best_length;
  assign result.is_last     = status.emit_last;

endmodule

// ===== hdl/longest_simple_path_search_unit.sv =====
// top level of the longest simple path search unit
// Usage: set vertex_count over the APB port (byte address 0) while the unit is idle,
// then send items on the item channel (item_valid / item_stall / item).
// A load item (opcode 0) writes one adjacency row; loads can follow back to back
// and give no result. A search item (opcode 1) runs an exhaustive depth-first walk
// from each start vertex in turn, stopping early once a path covers all vertices.
// Each start vertex tried gets its own push, then one push or pop per step, and is
// closed out when the stack is found empty or by the early stop; after the last
// start the unit hands over to output. The walk length depends on the graph and
// can grow exponentially with vertex_count.
// The found path then leaves on the result channel, one vertex per transaction,
// advancing whenever result_stall is low; is_last marks the final vertex.
// While a search or its output is in progress item_stall is high. A stalled result
// holds its payload and no new item is taken until the path is fully delivered.
// Reset (synchronous, active high) returns the unit to idle, clears the best length
// and stack, and sets vertex_count to 1; adjacency rows must be loaded again.
module longest_simple_path_search_unit
  import lsps_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  item_t                 item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result
);

  localparam int ROW_LIMIT = row_limit(MAX_VERTICES);

  logic [COUNT_W-1:0] vertex_count;
  logic [COUNT_W-1:0] active_count;
  logic               reg_sel;
  cmd_t               cmd;
  status_t            status;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_VERTEX_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= COUNT_W'(1);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      vertex_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(vertex_count) : '0;

  // zero acts as one, large values saturate at the row limit
  always_comb begin
    if (vertex_count == '0) begin
      active_count = COUNT_W'(1);
    end else if (vertex_count > COUNT_W'(ROW_LIMIT)) begin
      active_count = COUNT_W'(ROW_LIMIT);
    end else begin
      active_count = vertex_count;
    end
  end

  lsps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .opcode       (item.opcode),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  lsps_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .item         (item),
    .active_count (active_count),
    .status       (status),
    .result       (result)
  );

  // the input side stays closed while a path is being delivered
  a_no_accept_while_emit: assert property (@(posedge clk) disable iff (rst)
    !item_stall |-> !result_valid)
    else $error("item channel open during path output");

  // a search transaction closes the input side on the next cycle
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall && item.opcode == OP_SEARCH) |=> item_stall)
    else $error("search did not occupy the unit");

  // the last vertex taken ends the output burst
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall && result.is_last) |=> !result_valid)
    else $error("result continued after last vertex");

  // every delivered path holds at least one vertex and fits the vertex count
  a_length_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.path_length != '0) && (result.path_length <= active_count))
    else $error("path length out of range");

endmodule
